>>> rtl/core/fpt_pkg.sv
// ----------------------------------------------------------------------------
// fpt_pkg
// Shared types, codes and the speed ladder of the frame pacing throttle.
// ----------------------------------------------------------------------------
package fpt_pkg;

    // Timestamp width; time arithmetic wraps modulo 2^TIME_W
    localparam int TIME_W      = 64;
    localparam int CFG_W       = 41;
    localparam int TFREQ_W     = 41;
    localparam int BRATE_W     = 32;
    localparam int SCALE_W     = 15;
    localparam int PCT_W       = 13;
    localparam int PERIOD_W    = 64;
    localparam int CMD_W       = 3;
    localparam int CODE_W      = 3;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 96;

    // Divider geometry: dividend is timer_freq << 16, divisor the 31-bit rate
    localparam int DIVIDEND_W  = TFREQ_W + 16;
    localparam int RATE_W      = BRATE_W - 8 + SCALE_W - 8;
    localparam int DCNT_W      = $clog2(DIVIDEND_W);
    localparam int LIDX_W      = 5;
    localparam int LADDER_LEN  = 19;

    localparam logic [SCALE_W-1:0] NORMAL_SCALE  = SCALE_W'(256);
    localparam logic [PERIOD_W-1:0] WAIT_THRESH  = PERIOD_W'(65536);
    localparam logic [TFREQ_W-1:0] TFREQ_RESET   = TFREQ_W'(1000);
    localparam logic [BRATE_W-1:0] BRATE_RESET   = BRATE_W'(1008307711);

    typedef enum logic [0:0] {
        REG_TIMER_FREQ = 1'b0,
        REG_BASE_RATE  = 1'b1
    } cfg_reg_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_CHECK   = 3'd0,
        CMD_RESYNC  = 3'd1,
        CMD_SLOWEST = 3'd2,
        CMD_SLOWER  = 3'd3,
        CMD_NORMAL  = 3'd4,
        CMD_FASTER  = 3'd5,
        CMD_FASTEST = 3'd6,
        CMD_UNUSED  = 3'd7
    } cmd_t;

    typedef enum logic [CODE_W-1:0] {
        EV_ARMED       = 3'd0,
        EV_ON_TIME     = 3'd1,
        EV_WAIT        = 3'd2,
        EV_LATE_RESYNC = 3'd3,
        EV_CATCH_UP    = 3'd4,
        EV_RESYNC_DONE = 3'd5,
        EV_SPEED_SET   = 3'd6
    } event_t;

    // Speed ladder in 1/256 units
    function automatic logic [SCALE_W-1:0] ladder(input logic [LIDX_W-1:0] idx);
        logic [SCALE_W-1:0] v;
        begin
            unique case (idx)
                5'd0:    v = SCALE_W'(3);
                5'd1:    v = SCALE_W'(3);
                5'd2:    v = SCALE_W'(4);
                5'd3:    v = SCALE_W'(8);
                5'd4:    v = SCALE_W'(16);
                5'd5:    v = SCALE_W'(32);
                5'd6:    v = SCALE_W'(64);
                5'd7:    v = SCALE_W'(128);
                5'd8:    v = SCALE_W'(192);
                5'd9:    v = SCALE_W'(256);
                5'd10:   v = SCALE_W'(384);
                5'd11:   v = SCALE_W'(512);
                5'd12:   v = SCALE_W'(768);
                5'd13:   v = SCALE_W'(1024);
                5'd14:   v = SCALE_W'(2048);
                5'd15:   v = SCALE_W'(4096);
                5'd16:   v = SCALE_W'(8192);
                5'd17:   v = SCALE_W'(16384);
                5'd18:   v = SCALE_W'(16384);
                default: v = SCALE_W'(16384);
            endcase
            return v;
        end
    endfunction

endpackage

>>> rtl/core/frame_pacing_throttle_unit.sv
// ----------------------------------------------------------------------------
// frame_pacing_throttle_unit
// Frame pacer: speed ladder, frame period divider and frame timing check.
// ----------------------------------------------------------------------------
// Usage:
//   One item per video frame enters on s_axis_*: a command and the current
//   timestamp. Each item except the unused command code yields exactly one
//   result item on m_axis_*: an event code, the speed scale, the speed in
//   percent and the frame period in force after the command.
//   timer_freq and base_rate are written through cfg_we/cfg_index/cfg_data.
//   The user must write them while the block is idle; it has no check for it.
//   Steps in order: the ladder walk for slower/faster, the multiply, the
//   57-step restoring divider (one quotient bit per cycle, shared
//   subtractor), the frame check for a check command (arming, or a delta
//   and a compare once armed) and the output load. s_axis_tready is high
//   only in the idle state.
//   The finished result sits in an output register, so the next item is
//   accepted while a result waits; if the receiver still stalls when the
//   following result is done, the sequencer holds it until the register frees.
//   Reset: pacer unarmed, speed scale 256, registers at their defaults,
//   no result pending.
// ----------------------------------------------------------------------------
module frame_pacing_throttle_unit
(
    input  logic                              clk,
    input  logic                              rst_n,
    // cfg_data: timer_freq [40:0] or base_rate [31:0]
    input  logic                              cfg_we,
    input  logic [0:0]                        cfg_index,
    input  logic [fpt_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // s_axis_tdata: cmd [2:0], now_time [66:3], zero fill [71:67]
    input  logic [fpt_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // m_axis_tdata: event_code [2:0], speed_scale_out [17:3],
    //               speed_percent [30:18], frame_period [94:31], zero [95]
    output logic [fpt_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);
    import fpt_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_SCAN = 7'b0000010,
        ST_MUL  = 7'b0000100,
        ST_DIV  = 7'b0001000,
        ST_CHK1 = 7'b0010000,
        ST_CHK2 = 7'b0100000,
        ST_WB   = 7'b1000000
    } state_t;

    // Control and architectural state (reset)
    state_t                 state_reg, state_next;
    logic                   m_valid_reg, m_valid_next;
    logic [TIME_W-1:0]      last_time_reg, last_time_next;
    logic [SCALE_W-1:0]     scale_reg, scale_next;
    logic [TFREQ_W-1:0]     tfreq_reg, tfreq_next;
    logic [BRATE_W-1:0]     brate_reg, brate_next;
    logic [DCNT_W-1:0]      cnt_reg, cnt_next;
    logic [LIDX_W-1:0]      idx_reg, idx_next;

    // Working payload (no reset)
    cmd_t                   cmd_reg, cmd_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [TIME_W-1:0]      delta_reg, delta_next;
    logic [RATE_W-1:0]      rate_reg, rate_next;
    logic [DIVIDEND_W-1:0]  dq_reg, dq_next;
    logic [RATE_W-1:0]      rem_reg, rem_next;
    logic [PERIOD_W-1:0]    period_reg, period_next;
    event_t                 code_reg, code_next;
    logic [OUT_DATA_W-1:0]  out_reg, out_next;

    // Shared datapath terms
    logic [RATE_W+7:0]         prod;        // (base_rate >> 8) * scale
    logic [RATE_W:0]           trial;
    logic                      q_bit;
    logic [PERIOD_W-1:0]       dz;
    logic [21:0]               pct_full;
    logic                      accept;
    logic                      out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign prod     = (RATE_W+8)'(brate_reg[BRATE_W-1:8]) *
                      (RATE_W+8)'(scale_reg);
    // One restoring-division step: shift in the next dividend bit, try subtract
    assign trial    = {rem_reg, dq_reg[DIVIDEND_W-1]};
    assign q_bit    = (trial >= {1'b0, rate_reg});
    assign dz       = PERIOD_W'(delta_reg);
    assign pct_full = 22'(scale_reg) * 22'd100;

    always_comb
    begin
        state_next     = state_reg;
        m_valid_next   = m_valid_reg;
        last_time_next = last_time_reg;
        scale_next     = scale_reg;
        tfreq_next     = tfreq_reg;
        brate_next     = brate_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        cmd_next       = cmd_reg;
        now_next       = now_reg;
        delta_next     = delta_reg;
        rate_next      = rate_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        period_next    = period_reg;
        code_next      = code_reg;
        out_next       = out_reg;

        // Drop the result once the receiver takes it
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TIMER_FREQ: tfreq_next = cfg_data[TFREQ_W-1:0];
                REG_BASE_RATE:  brate_next = cfg_data[BRATE_W-1:0];
                default:        tfreq_next = tfreq_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_next = cmd_t'(s_axis_tdata[CMD_W-1:0]);
                    now_next = s_axis_tdata[CMD_W +: TIME_W];
                    idx_next = LIDX_W'(1);
                    unique case (cmd_t'(s_axis_tdata[CMD_W-1:0]))
                        CMD_CHECK:
                        begin
                            state_next = ST_MUL;
                        end
                        CMD_RESYNC:
                        begin
                            last_time_next = '0;
                            code_next      = EV_RESYNC_DONE;
                            state_next     = ST_MUL;
                        end
                        CMD_SLOWEST:
                        begin
                            scale_next = ladder(LIDX_W'(0));
                            code_next  = EV_SPEED_SET;
                            state_next = ST_MUL;
                        end
                        CMD_NORMAL:
                        begin
                            scale_next = NORMAL_SCALE;
                            code_next  = EV_SPEED_SET;
                            state_next = ST_MUL;
                        end
                        CMD_FASTEST:
                        begin
                            scale_next = ladder(LIDX_W'(LADDER_LEN - 1));
                            code_next  = EV_SPEED_SET;
                            state_next = ST_MUL;
                        end
                        CMD_SLOWER, CMD_FASTER:
                        begin
                            code_next  = EV_SPEED_SET;
                            state_next = ST_SCAN;
                        end
                        CMD_UNUSED:
                        begin
                            state_next = ST_IDLE;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // Advance to the first ladder entry not below the scale
                if (idx_reg < LIDX_W'(LADDER_LEN - 2) && ladder(idx_reg) < scale_reg)
                begin
                    idx_next = idx_reg + LIDX_W'(1);
                end
                else
                begin
                    if (cmd_reg == CMD_SLOWER)
                    begin
                        scale_next = ladder(idx_reg - LIDX_W'(1));
                    end
                    else
                    begin
                        scale_next = ladder(idx_reg + LIDX_W'(1));
                    end
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                rate_next  = prod[RATE_W+7:8];
                dq_next    = {tfreq_reg, 16'd0};
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                rem_next = q_bit ? RATE_W'(trial - {1'b0, rate_reg}) : RATE_W'(trial);
                dq_next  = {dq_reg[DIVIDEND_W-2:0], q_bit};
                cnt_next = cnt_reg + DCNT_W'(1);
                if (cnt_reg == DCNT_W'(DIVIDEND_W - 1))
                begin
                    if (rate_reg == '0)
                    begin
                        period_next = '1;
                    end
                    else
                    begin
                        period_next = PERIOD_W'({dq_reg[DIVIDEND_W-2:0], q_bit});
                    end
                    state_next = (cmd_reg == CMD_CHECK) ? ST_CHK1 : ST_WB;
                end
            end

            ST_CHK1:
            begin
                if (last_time_reg == '0)
                begin
                    // Unarmed: arm on this timestamp
                    last_time_next = now_reg;
                    code_next      = EV_ARMED;
                    state_next     = ST_WB;
                end
                else
                begin
                    delta_next = now_reg - last_time_reg;
                    state_next = ST_CHK2;
                end
            end

            ST_CHK2:
            begin
                if (dz < period_reg)
                begin
                    if ((period_reg - dz) >= WAIT_THRESH)
                    begin
                        code_next = EV_WAIT;
                    end
                    else
                    begin
                        last_time_next = last_time_reg + period_reg[TIME_W-1:0];
                        code_next      = EV_ON_TIME;
                    end
                end
                else if ((dz - period_reg) > period_reg)
                begin
                    // More than two periods behind: disarm
                    last_time_next = '0;
                    code_next      = EV_LATE_RESYNC;
                end
                else
                begin
                    last_time_next = last_time_reg + period_reg[TIME_W-1:0];
                    code_next      = EV_CATCH_UP;
                end
                state_next = ST_WB;
            end

            ST_WB:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    out_next     = {1'b0, period_reg, pct_full[PCT_W+7:8], scale_reg,
                                    code_reg};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            last_time_reg <= '0;
            scale_reg     <= NORMAL_SCALE;
            tfreq_reg     <= TFREQ_RESET;
            brate_reg     <= BRATE_RESET;
            cnt_reg       <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            last_time_reg <= last_time_next;
            scale_reg     <= scale_next;
            tfreq_reg     <= tfreq_next;
            brate_reg     <= brate_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        now_reg    <= now_next;
        delta_reg  <= delta_next;
        rate_reg   <= rate_next;
        dq_reg     <= dq_next;
        rem_reg    <= rem_next;
        period_reg <= period_next;
        code_reg   <= code_next;
        out_reg    <= out_next;
    end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for frame_pacing_throttle_unit. A behavioral pacer
// (speed ladder, period division, frame timing check) runs alongside the
// block. It predicts one report per accepted command other than the unused
// code. The report is compared field by field with what leaves the master
// stream. Directed tests cover the ladder ends, every timing outcome and the
// register extremes. Random phases under new register settings follow, with
// stamps placed around the period boundaries.
// ----------------------------------------------------------------------------
module testbench;
    import fpt_pkg::*;

    localparam int          DRAIN_CYCLES   = 100;   // beyond the worst item latency
    localparam int          STALL_LIMIT    = 4000;  // cycles with no item moving
    localparam int          PHASES         = 6;
    localparam int          PHASE_ITEMS    = 250;
    localparam logic [14:0] NORMAL_SPEED   = 15'd256;
    localparam logic [63:0] WAIT_MARGIN    = 64'd65536;

    // Report of the pacer for one command
    typedef struct packed {
        event_t      code;
        logic [14:0] scale;
        logic [12:0] pct;
        logic [63:0] period;
    } pace_report_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [0:0]            cfg_index     = '0;
    logic [CFG_W-1:0]      cfg_data      = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // cmd [2:0], now_time [66:3], zero fill [71:67]
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    // event_code [2:0], speed_scale_out [17:3], speed_percent [30:18],
    // frame_period [94:31], zero [95]
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // Pacer state and register copies kept by the bench
    logic [63:0] pace_last_time = '0;
    logic [14:0] pace_scale     = NORMAL_SPEED;
    logic [40:0] cfg_tfreq      = 41'd1000;
    logic [31:0] cfg_brate      = 32'd1008307711;

    logic [14:0] speed_steps [0:18] = '{15'd3, 15'd3, 15'd4, 15'd8, 15'd16, 15'd32,
        15'd64, 15'd128, 15'd192, 15'd256, 15'd384, 15'd512, 15'd768, 15'd1024,
        15'd2048, 15'd4096, 15'd8192, 15'd16384, 15'd16384};

    pace_report_t pacer_reports_q [$];
    int           fault_count  = 0;
    int           report_count = 0;
    int           quiet_cycles = 0;
    bit           idle_on      = 1'b1;

    frame_pacing_throttle_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Pacer arithmetic
    // ------------------------------------------------------------------

    // Ticks per frame: (timer_freq << 16) / rate, all ones when rate is zero
    function automatic logic [63:0] period_of(input logic [40:0] tf, input logic [31:0] br,
                                              input logic [14:0] sc);
        logic [63:0] rate;
        rate = ((64'(br) >> 8) * 64'(sc)) >> 8;
        if (rate == 64'd0)
            return '1;
        return (64'(tf) << 16) / rate;
    endfunction

    function automatic logic [63:0] period_now();
        return period_of(cfg_tfreq, cfg_brate, pace_scale);
    endfunction

    // First rung from index 1 that is not below the scale, capped at 17
    function automatic int rung_of(input logic [14:0] sc);
        int i;
        i = 1;
        while (i < 17 && speed_steps[i] < sc)
            i++;
        return i;
    endfunction

    // Advance the pacer by one command; return 0 when the command is dropped
    function automatic bit pace_predict(input cmd_t op, input logic [63:0] stamp,
                                        output pace_report_t rep);
        logic [63:0] per;
        logic [63:0] delta;
        event_t      code;
        rep  = '0;
        code = EV_SPEED_SET;
        case (op)
            CMD_CHECK:
            begin
                per = period_now();
                if (pace_last_time == 64'd0)
                begin
                    // a zero stamp leaves the pacer unarmed
                    pace_last_time = stamp;
                    code = EV_ARMED;
                end
                else
                begin
                    delta = stamp - pace_last_time;
                    if (delta < per)
                    begin
                        if (per - delta >= WAIT_MARGIN)
                            code = EV_WAIT;
                        else
                        begin
                            pace_last_time = pace_last_time + per;
                            code = EV_ON_TIME;
                        end
                    end
                    else if (delta - per > per)
                    begin
                        pace_last_time = '0;
                        code = EV_LATE_RESYNC;
                    end
                    else
                    begin
                        // a sum that wraps to zero disarms as well
                        pace_last_time = pace_last_time + per;
                        code = EV_CATCH_UP;
                    end
                end
            end
            CMD_RESYNC:
            begin
                pace_last_time = '0;
                code = EV_RESYNC_DONE;
            end
            CMD_SLOWEST: pace_scale = speed_steps[0];
            CMD_SLOWER:  pace_scale = speed_steps[rung_of(pace_scale) - 1];
            CMD_NORMAL:  pace_scale = NORMAL_SPEED;
            CMD_FASTER:  pace_scale = speed_steps[rung_of(pace_scale) + 1];
            CMD_FASTEST: pace_scale = speed_steps[18];
            default:     return 1'b0;
        endcase
        rep.code   = code;
        rep.scale  = pace_scale;
        rep.pct    = 13'((32'(pace_scale) * 100) >> 8);
        rep.period = period_now();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Value in [lo, hi], landing on either end half of the time
    function automatic logic [63:0] pick_between(input logic [63:0] lo, input logic [63:0] hi);
        logic [63:0] span;
        if (hi <= lo)
            return lo;
        span = hi - lo;
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            default: return (span == '1) ? rand64() : lo + (rand64() % (span + 64'd1));
        endcase
    endfunction

    function automatic cmd_t pick_cmd();
        int bucket;
        bucket = $urandom_range(0, 99);
        if (bucket < 60)      return CMD_CHECK;
        else if (bucket < 65) return CMD_RESYNC;
        else if (bucket < 68) return CMD_SLOWEST;
        else if (bucket < 77) return CMD_SLOWER;
        else if (bucket < 80) return CMD_NORMAL;
        else if (bucket < 89) return CMD_FASTER;
        else if (bucket < 93) return CMD_FASTEST;
        else                  return CMD_UNUSED;
    endfunction

    // Place frame checks mostly around the period boundaries of the armed pacer
    function automatic logic [63:0] pick_stamp(input cmd_t op);
        logic [63:0] per;
        logic [63:0] delta;
        if (op != CMD_CHECK)
            return rand64();
        if (pace_last_time == 64'd0)
            return ($urandom_range(0, 9) == 0) ? 64'd0 : rand64();
        per = period_now();
        case ($urandom_range(0, 4))
            0:  // plenty of time left
                delta = (per >= WAIT_MARGIN) ? pick_between(64'd0, per - WAIT_MARGIN)
                                             : rand64();
            1:  // inside the on-time window
                delta = (per == 64'd0) ? rand64()
                      : pick_between((per > 64'd65535) ? per - 64'd65535 : 64'd0,
                                     per - 64'd1);
            2:  // one to two periods elapsed
                delta = pick_between(per, (per <= (64'h7FFF_FFFF_FFFF_FFFF)) ? 2 * per : '1);
            3:  // more than two periods elapsed
                delta = (per < 64'h7FFF_FFFF_FFFF_FFFF) ? pick_between(2 * per + 64'd1, '1)
                                                        : rand64();
            default:
                return rand64();
        endcase
        return pace_last_time + delta;
    endfunction

    function automatic logic [40:0] pick_tfreq();
        case ($urandom_range(0, 7))
            0:       return 41'd1;
            1:       return 41'h100_0000_0000;
            2:       return 41'd1000;
            3:       return 41'd1_000_000;
            4:       return 41'd1_000_000_000;
            5:       return 41'd0;
            default: return 41'(rand64());
        endcase
    endfunction

    // Base rate in the low bits; junk above bit 31 must be ignored
    function automatic logic [40:0] pick_brate();
        logic [31:0] rate;
        case ($urandom_range(0, 5))
            0:       rate = 32'd1;
            1:       rate = 32'hFFFF_FFFF;
            2:       rate = 32'd1008307711;
            3:       rate = 32'($urandom_range(256, 65535));
            default: rate = $urandom;
        endcase
        return {9'($urandom), rate};
    endfunction

    // ------------------------------------------------------------------
    // Stimulus primitives; each is entered at a rising edge
    // ------------------------------------------------------------------

    task automatic send_item(input cmd_t op, input logic [63:0] stamp);
        pace_report_t rep;
        bit           produces;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, stamp, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        // accepted at this edge: hold valid high for a possible next item
        produces = pace_predict(op, stamp, rep);
        if (produces)
            pacer_reports_q.push_back(rep);
    endtask

    task automatic check_after(input logic [63:0] delta);
        send_item(CMD_CHECK, pace_last_time + delta);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [40:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_TIMER_FREQ: cfg_tfreq = value;
            REG_BASE_RATE:  cfg_brate = value[31:0];
        endcase
    endtask

    // Drop valid, drain every report, then cover a dropped item still in flight
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        while (pacer_reports_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Default registers: period is 16 ticks, so checks never wait
    task automatic test_reset_defaults();
        send_item(CMD_CHECK, 64'd0);
        send_item(CMD_CHECK, 64'd5);
        check_after(64'd10);
        send_item(CMD_UNUSED, rand64());
    endtask

    task automatic test_speed_ladder();
        send_item(CMD_SLOWEST, rand64());
        send_item(CMD_SLOWER, rand64());   // already at the bottom rung
        send_item(CMD_FASTER, rand64());
        send_item(CMD_FASTEST, rand64());
        send_item(CMD_FASTER, rand64());   // already at the top rung
        send_item(CMD_SLOWER, rand64());
        send_item(CMD_NORMAL, rand64());
    endtask

    // Nanosecond timer: the period is about 16.6M ticks
    task automatic test_frame_timing();
        logic [63:0] per;
        quiesce();
        write_reg(REG_TIMER_FREQ, 41'd1_000_000_000);
        per = period_now();
        send_item(CMD_CHECK, '1);          // arm at the top of the time range
        check_after(per - WAIT_MARGIN);    // one margin short: wait
        check_after(per - 64'd65535);      // just inside: on time, stored time wraps
        check_after(per);                  // exactly one period: catch-up
        check_after(2 * per);              // exactly two periods: still catch-up
        check_after(2 * per + 64'd1);      // beyond two periods: late resync
        send_item(CMD_CHECK, 64'd0 - per); // arm one period below the wrap
        check_after(per);                  // catch-up lands on zero and disarms
        send_item(CMD_CHECK, 64'd1);
        send_item(CMD_RESYNC, rand64());
    endtask

    task automatic test_register_extremes();
        // base rate of 1 gives a zero rate: saturated period; an early check waits, a late one is on time
        quiesce();
        write_reg(REG_TIMER_FREQ, 41'h100_0000_0000);
        write_reg(REG_BASE_RATE, 41'd1);
        send_item(CMD_CHECK, rand64());
        check_after(64'd1000);
        check_after(64'hFFFF_FFFF_FFFF_FF9B);
        send_item(CMD_FASTEST, rand64());
        // fastest rate against the slowest timer: zero period
        quiesce();
        write_reg(REG_BASE_RATE, {9'h1FF, 32'hFFFF_FFFF});
        write_reg(REG_TIMER_FREQ, 41'd1);
        send_item(CMD_RESYNC, rand64());
        send_item(CMD_CHECK, 64'd77);
        check_after(64'd0);
        check_after(64'd1);
        // zero timer frequency, nominal base rate with junk above it
        quiesce();
        write_reg(REG_TIMER_FREQ, 41'd0);
        write_reg(REG_BASE_RATE, {9'h155, 32'd1008307711});
        send_item(CMD_NORMAL, rand64());
        send_item(CMD_CHECK, rand64());
        check_after(64'd0);
    endtask

    // Random phases, each under fresh register values; the last one runs
    // without idling on either side
    task automatic test_random_traffic();
        cmd_t        op;
        logic [63:0] stamp;
        int          counted;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            quiesce();
            idle_on = (phase != PHASES - 1);
            write_reg(REG_TIMER_FREQ, pick_tfreq());
            write_reg(REG_BASE_RATE, pick_brate());
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                op    = pick_cmd();
                stamp = pick_stamp(op);
                send_item(op, stamp);
                if (op != CMD_UNUSED)
                    counted++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_speed_ladder();
        test_frame_timing();
        test_register_extremes();
        test_random_traffic();
        quiesce();
        if (fault_count == 0 && pacer_reports_q.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Receiver: random stall bursts, each followed by a stretch of free flow
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(0, 40)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_fault(input string what);
        if (fault_count < 10)
            $display("mismatch: %s", what);
        fault_count++;
    endtask

    always @(posedge clk)
    begin : check_reports
        pace_report_t got;
        pace_report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.code   = event_t'(m_axis_tdata[2:0]);
            got.scale  = m_axis_tdata[17:3];
            got.pct    = m_axis_tdata[30:18];
            got.period = m_axis_tdata[94:31];
            if (pacer_reports_q.size() == 0)
                report_fault($sformatf("report %0d arrived with none expected", report_count));
            else
            begin
                want = pacer_reports_q.pop_front();
                if (got.code !== want.code || got.scale !== want.scale ||
                    got.pct !== want.pct || got.period !== want.period)
                    report_fault($sformatf({"report %0d: expected code %0d scale %0d ",
                        "pct %0d period %h, got code %0d scale %0d pct %0d period %h"},
                        report_count, want.code, want.scale, want.pct, want.period,
                        got.code, got.scale, got.pct, got.period));
            end
            report_count++;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

endmodule
